// ----- src/bqg_pkg.sv -----
// bqg_pkg: shared types, widths and register codes for the biquad filter with gain
// used by bqg_mac and biquad_df2_filter_with_gain; no dependencies
package bqg_pkg;

   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 18;
   localparam int GAIN_W   = 16;
   localparam int STATE_W  = 24;
   localparam int MUL_A_W  = 28;
   localparam int MUL_B_W  = 18;
   localparam int ACC_W    = MUL_A_W + MUL_B_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   localparam logic [CSR_IDX_W-1:0] CSR_B0   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_B1   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_B2   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_A1   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_A2   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN = 3'd5;

   localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd32768;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_in;
      logic                       frame_end;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       frame_end_out;
   } rsp_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB
   } acc_op_type;

   typedef struct packed {
      logic       mul_en;
      acc_op_type acc_op;
   } mac_ctrl_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FB1,
      S_FB2,
      S_FB3,
      S_W,
      S_FF0,
      S_FF1,
      S_FF2,
      S_FF3,
      S_Y,
      S_G,
      S_OUT
   } state_type;

endpackage

// ----- src/bqg_mac.sv -----
// bqg_mac: shared multiplier with registered product and a 46 bit accumulator
// depends on bqg_pkg
module bqg_mac (
   input  logic                                  clock,
   input  logic                                  reset,
   input  bqg_pkg::mac_ctrl_type                 ctrl,
   input  logic signed [bqg_pkg::MUL_A_W-1:0]    mul_a,
   input  logic signed [bqg_pkg::MUL_B_W-1:0]    mul_b,
   input  logic signed [bqg_pkg::ACC_W-1:0]      load_value,
   output logic signed [bqg_pkg::ACC_W-1:0]      product,
   output logic signed [bqg_pkg::ACC_W-1:0]      acc
);
   import bqg_pkg::*;

   logic signed [ACC_W-1:0] prod_ff;
   logic signed [ACC_W-1:0] prod_in;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;

   always_comb begin
      prod_in = prod_ff;
      if (ctrl.mul_en) begin
         prod_in = mul_a * mul_b;
      end
      case (ctrl.acc_op)
         ACC_HOLD: acc_in = acc_ff;
         ACC_LOAD: acc_in = load_value;
         ACC_ADD:  acc_in = acc_ff + prod_ff;
         ACC_SUB:  acc_in = acc_ff - prod_ff;
         default:  acc_in = acc_ff;
      endcase
   end

   // datapath only, held while in reset
   always_ff @(posedge clock) begin
      if (!reset) begin
         prod_ff <= prod_in;
         acc_ff  <= acc_in;
      end
   end

   assign product = prod_ff;
   assign acc     = acc_ff;

endmodule

// ----- src/biquad_df2_filter_with_gain.sv -----
// biquad_df2_filter_with_gain: direct form II biquad section with output volume gain
// depends on bqg_pkg and bqg_mac
//
// One 16 bit sample per request. Between acceptance and its result being loaded into
// the output register, six products (a1, a2, b0, b1, b2 and the gain) go through the
// single 28x18 multiplier of bqg_mac one after the other, with rounding and
// saturation steps in between. The next request is taken as soon as the previous
// result sits in the output register, which waits while the output side stalls; no
// new sample is accepted while one is in flight. Filter state is Q4.20, saturated, and
// carries on across frame ends. Coefficients and gain must be written through the csr
// port only while the block is idle; it does not enforce this. Indexes above 5 are ignored.
module biquad_df2_filter_with_gain (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  bqg_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output bqg_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bqg_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [bqg_pkg::CSR_DATA_W-1:0]        csr_data
);
   import bqg_pkg::*;

   localparam logic signed [ACC_W-1:0] RND_16  = ACC_W'(32768);
   localparam logic signed [ACC_W-1:0] RND_20  = ACC_W'(524288);
   localparam logic signed [ACC_W-1:0] W_MAX   = ACC_W'(8388607);
   localparam logic signed [ACC_W-1:0] W_MIN   = -ACC_W'(8388608);
   localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] OUT_MIN = -ACC_W'(32768);

   state_type state_ff, state_in;

   logic signed [COEF_W-1:0]  coef_b0_ff, coef_b1_ff, coef_b2_ff, coef_a1_ff, coef_a2_ff;
   logic [GAIN_W-1:0]         gain_ff;
   logic signed [STATE_W-1:0] delay_one_ff, delay_two_ff, w_ff;
   logic signed [MUL_A_W-1:0] y_ff;
   logic signed [SAMPLE_W-1:0] x_ff;
   logic                      frame_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff;

   mac_ctrl_type              mac_ctrl;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [ACC_W-1:0]   load_value;
   logic signed [ACC_W-1:0]   product;
   logic signed [ACC_W-1:0]   acc;

   logic signed [ACC_W-1:0]   w_round, y_round, o_round;
   logic signed [STATE_W-1:0] w_sat;
   logic signed [SAMPLE_W-1:0] o_sat;
   logic                      req_take, out_load, csr_write;

   bqg_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (mac_ctrl),
      .mul_a      (mul_a),
      .mul_b      (mul_b),
      .load_value (load_value),
      .product    (product),
      .acc        (acc)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_load  = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // rounding and saturation
   always_comb begin
      w_round = (acc + RND_16) >>> 16;
      y_round = (acc + RND_16) >>> 16;
      o_round = (product + RND_20) >>> 20;
      if (w_round > W_MAX) begin
         w_sat = W_MAX[STATE_W-1:0];
      end else if (w_round < W_MIN) begin
         w_sat = W_MIN[STATE_W-1:0];
      end else begin
         w_sat = w_round[STATE_W-1:0];
      end
      if (o_round > OUT_MAX) begin
         o_sat = OUT_MAX[SAMPLE_W-1:0];
      end else if (o_round < OUT_MIN) begin
         o_sat = OUT_MIN[SAMPLE_W-1:0];
      end else begin
         o_sat = o_round[SAMPLE_W-1:0];
      end
   end

   // sequencer: next state, mac control and operand selection
   always_comb begin
      state_in        = state_ff;
      mac_ctrl.mul_en = 1'b0;
      mac_ctrl.acc_op = ACC_HOLD;
      mul_a           = MUL_A_W'(delay_one_ff);
      mul_b           = coef_a1_ff;
      load_value      = '0;
      case (state_ff)
         S_IDLE: begin
            load_value = {{(ACC_W-SAMPLE_W-21){req_data.sample_in[SAMPLE_W-1]}},
                          req_data.sample_in, 21'b0};
            if (req_take) begin
               mac_ctrl.acc_op = ACC_LOAD;
               state_in        = S_FB1;
            end
         end
         S_FB1: begin
            mac_ctrl.mul_en = 1'b1;
            state_in        = S_FB2;
         end
         S_FB2: begin
            mul_a           = MUL_A_W'(delay_two_ff);
            mul_b           = coef_a2_ff;
            mac_ctrl.mul_en = 1'b1;
            mac_ctrl.acc_op = ACC_SUB;
            state_in        = S_FB3;
         end
         S_FB3: begin
            mac_ctrl.acc_op = ACC_SUB;
            state_in        = S_W;
         end
         S_W: begin
            mac_ctrl.acc_op = ACC_LOAD;
            state_in        = S_FF0;
         end
         S_FF0: begin
            mul_a           = MUL_A_W'(w_ff);
            mul_b           = coef_b0_ff;
            mac_ctrl.mul_en = 1'b1;
            state_in        = S_FF1;
         end
         S_FF1: begin
            mul_a           = MUL_A_W'(delay_one_ff);
            mul_b           = coef_b1_ff;
            mac_ctrl.mul_en = 1'b1;
            mac_ctrl.acc_op = ACC_ADD;
            state_in        = S_FF2;
         end
         S_FF2: begin
            mul_a           = MUL_A_W'(delay_two_ff);
            mul_b           = coef_b2_ff;
            mac_ctrl.mul_en = 1'b1;
            mac_ctrl.acc_op = ACC_ADD;
            state_in        = S_FF3;
         end
         S_FF3: begin
            mac_ctrl.acc_op = ACC_ADD;
            state_in        = S_Y;
         end
         S_Y: begin
            state_in = S_G;
         end
         S_G: begin
            mul_a           = y_ff;
            mul_b           = {2'b00, gain_ff};
            mac_ctrl.mul_en = 1'b1;
            state_in        = S_OUT;
         end
         S_OUT: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_b0_ff <= '0;
         coef_b1_ff <= '0;
         coef_b2_ff <= '0;
         coef_a1_ff <= '0;
         coef_a2_ff <= '0;
         gain_ff    <= GAIN_UNITY;
      end else if (csr_write) begin
         case (csr_index)
            CSR_B0:   coef_b0_ff <= csr_data[COEF_W-1:0];
            CSR_B1:   coef_b1_ff <= csr_data[COEF_W-1:0];
            CSR_B2:   coef_b2_ff <= csr_data[COEF_W-1:0];
            CSR_A1:   coef_a1_ff <= csr_data[COEF_W-1:0];
            CSR_A2:   coef_a2_ff <= csr_data[COEF_W-1:0];
            CSR_GAIN: gain_ff    <= csr_data[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_one_ff <= '0;
         delay_two_ff <= '0;
      end else if (out_load) begin
         delay_two_ff <= delay_one_ff;
         delay_one_ff <= w_ff;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         x_ff     <= req_data.sample_in;
         frame_ff <= req_data.frame_end;
      end
      if (state_ff == S_W) begin
         w_ff <= w_sat;
      end
      if (state_ff == S_Y) begin
         y_ff <= y_round[MUL_A_W-1:0];
      end
      if (out_load) begin
         rsp_ff.sample_out    <= o_sat;
         rsp_ff.frame_end_out <= frame_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // the feedback sum starts from the sample just taken
   a_load_sample: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == S_FB1) && (acc >>> 21) == ACC_W'(x_ff))
      else $error("accumulator not loaded with the request sample");

   a_state_shift: assert property (@(posedge clock) disable iff (reset)
      !out_load |=> $stable(delay_one_ff) && $stable(delay_two_ff))
      else $error("filter state moved without a result");

   a_out_load: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff && (state_ff == S_IDLE)
                   && delay_one_ff == $past(w_ff))
      else $error("result load did not complete the request");

   a_busy_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_valid_ff && rsp_stall) |=> (state_ff == S_OUT)
                   && $stable(rsp_ff))
      else $error("result overwritten while output stalled");

endmodule
